// File: sv/utf8d_pkg.sv
// Package with the shared types and constants of the UTF-8 decoder.
package utf8d_pkg;

	// Width of a decoded code point.
	localparam int unsigned CP_W = 21;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_CHAR = 2'd0,
		ST_END  = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

	// Lead bytes that need extra range checks on later bytes, and the byte limits of those checks.
	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] LEAD_EF = 8'hEF;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;
	localparam logic [7:0] BYTE_BF = 8'hBF;
	localparam logic [7:0] MAX_F4_SECOND = 8'h8F;

	// Decoder state carried from word to word.
	typedef struct packed {
		logic [1:0]      pending;
		logic [CP_W-1:0] partial;
		logic [7:0]      lead;
		logic [7:0]      second;
		logic            discarding;
	} dec_state_t;

	// One result word.
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		status_t         status;
	} result_t;

endpackage

// File: sv/utf8d_if.sv
// Handshake interfaces for the byte input and the result output channels.
interface utf8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface utf8d_res_if;
	logic                          valid;
	logic                          ready;
	logic [utf8d_pkg::CP_W-1:0]    code_point;
	logic [1:0]                    status;

	modport source (output valid, output code_point, output status, input ready);
	modport sink (input valid, input code_point, input status, output ready);
endinterface

// File: sv/utf8d_step.sv
// Combinational next-state and result logic for one input byte.
module utf8d_step (
	input  logic [7:0]            in_byte,
	input  utf8d_pkg::dec_state_t cur,
	output utf8d_pkg::dec_state_t nxt,
	output logic                  res_valid,
	output utf8d_pkg::result_t    res
);

	logic       is_cont;
	logic [1:0] extra;
	logic       is_second;
	logic       bad_second;
	logic       bad_third;
	logic [1:0] pending_dec;
	logic [utf8d_pkg::CP_W-1:0] partial_shift;

	// Continuation checks that depend on the lead byte.
	always_comb begin
		is_cont = (in_byte[7:6] == 2'b10);
		if (cur.lead[7:5] == 3'b110) begin
			extra = 2'd1;
		end else if (cur.lead[7:4] == 4'b1110) begin
			extra = 2'd2;
		end else begin
			extra = 2'd3;
		end
		is_second = (cur.pending == extra);
		bad_second = ((cur.lead == utf8d_pkg::LEAD_E0) && (in_byte[7:5] == 3'b100))
			|| ((cur.lead == utf8d_pkg::LEAD_ED) && (in_byte[7:5] == 3'b101))
			|| ((cur.lead == utf8d_pkg::LEAD_F0) && (in_byte[7:4] == 4'b1000))
			|| ((cur.lead == utf8d_pkg::LEAD_F4) && (in_byte > utf8d_pkg::MAX_F4_SECOND));
		bad_third = (extra == 2'd2) && (cur.pending == 2'd1)
			&& (cur.lead == utf8d_pkg::LEAD_EF) && (cur.second == utf8d_pkg::BYTE_BF)
			&& (in_byte[7:1] == 7'b1011111);
		pending_dec = cur.pending - 2'd1;
		partial_shift = {cur.partial[utf8d_pkg::CP_W-7:0], in_byte[5:0]};
	end

	// Main decode: idle, inside a sequence, or discarding after an error.
	always_comb begin
		nxt = cur;
		res_valid = 1'b0;
		res.code_point = '0;
		res.status = utf8d_pkg::ST_CHAR;
		if (cur.discarding) begin
			if (in_byte == 8'h00) begin
				nxt = '0;
			end
		end else if (cur.pending == 2'd0) begin
			if (in_byte == 8'h00) begin
				res_valid = 1'b1;
				res.status = utf8d_pkg::ST_END;
			end else if (!in_byte[7]) begin
				res_valid = 1'b1;
				res.code_point = {{(utf8d_pkg::CP_W-8){1'b0}}, in_byte};
			end else if ((in_byte[7:5] == 3'b110) && (in_byte[4:1] != 4'b0000)) begin
				nxt.pending = 2'd1;
				nxt.partial = {{(utf8d_pkg::CP_W-5){1'b0}}, in_byte[4:0]};
				nxt.lead = in_byte;
				nxt.second = '0;
			end else if (in_byte[7:4] == 4'b1110) begin
				nxt.pending = 2'd2;
				nxt.partial = {{(utf8d_pkg::CP_W-4){1'b0}}, in_byte[3:0]};
				nxt.lead = in_byte;
				nxt.second = '0;
			end else if ((in_byte[7:3] == 5'b11110) && (in_byte <= utf8d_pkg::LEAD_F4)) begin
				nxt.pending = 2'd3;
				nxt.partial = {{(utf8d_pkg::CP_W-3){1'b0}}, in_byte[2:0]};
				nxt.lead = in_byte;
				nxt.second = '0;
			end else begin
				// Stray continuation, C0/C1 lead or lead above F4.
				nxt = '0;
				nxt.discarding = 1'b1;
				res_valid = 1'b1;
				res.status = utf8d_pkg::ST_ERR;
			end
		end else if (!is_cont || (is_second && bad_second) || bad_third) begin
			// Malformed sequence; a zero byte ends the string without discarding.
			nxt = '0;
			nxt.discarding = (in_byte != 8'h00);
			res_valid = 1'b1;
			res.status = utf8d_pkg::ST_ERR;
		end else begin
			nxt.partial = partial_shift;
			nxt.pending = pending_dec;
			if (is_second) begin
				nxt.second = in_byte;
			end
			if (pending_dec == 2'd0) begin
				nxt.partial = '0;
				nxt.lead = '0;
				nxt.second = '0;
				res_valid = 1'b1;
				res.code_point = partial_shift;
			end
		end
	end

endmodule

// File: sv/utf8d_obuf.sv
// Output register with a skid stage for result words.
module utf8d_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  utf8d_pkg::result_t push_data,
	output logic               can_push,
	output logic               out_valid,
	output utf8d_pkg::result_t out_data,
	input  logic               out_ready,
	output logic               skid_busy
);

	logic               out_valid_q;
	logic               skid_valid_q;
	utf8d_pkg::result_t out_q;
	utf8d_pkg::result_t skid_q;
	logic               pop;

	assign pop = out_valid_q && out_ready;
	assign can_push = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign skid_busy = skid_valid_q;

	// Valid flags of the output and skid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || pop) begin
			out_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// File: sv/utf8_validating_decoder_core.sv
// Top level of the streaming UTF-8 validating decoder.
//
//  channel  dir  payload                      words
//  din      in   in_byte[7:0]                 one raw string byte
//  dout     out  code_point[20:0], status[1:0] char, end or error result
//
// One byte is taken per clock while the skid register is empty. A byte is
// decoded against the sequence state while it sits in the input register,
// and its result (if any) is registered in the output register, or in the
// skid register while the output is stalled.
// Reset clears the sequence state and all valid flags at once.
// A stalled output fills the skid register; input stalls only while it is full.
module utf8_validating_decoder_core (
	input logic             clk,
	input logic             arst_n,
	utf8d_byte_if.sink      din,
	utf8d_res_if.source     dout
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	utf8d_pkg::dec_state_t state_q;
	utf8d_pkg::dec_state_t state_nxt;
	logic                  res_valid;
	utf8d_pkg::result_t    res;
	utf8d_pkg::result_t    out_data;
	logic                  can_push;
	logic                  advance;
	logic                  skid_busy;

	assign advance = valid_s1 && can_push;
	assign din.ready = !valid_s1 || can_push;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			byte_s1 <= din.in_byte;
		end
	end

	// Per-byte decode.
	utf8d_step u_step (
		.in_byte   (byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// Sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result output with skid stage.
	utf8d_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && res_valid),
		.push_data (res),
		.can_push  (can_push),
		.out_valid (dout.valid),
		.out_data  (out_data),
		.out_ready (dout.ready),
		.skid_busy (skid_busy)
	);

	assign dout.code_point = out_data.code_point;
	assign dout.status = out_data.status;

	// A full skid register always sits behind a full output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_busy |-> dout.valid)
		else $error("skid register full while output register empty");

	// Discarding never overlaps a sequence in progress.
	a_discard_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.discarding |-> (state_q.pending == 2'd0))
		else $error("discarding with continuation bytes pending");

	// A sequence in progress always has a multi-byte lead recorded.
	a_lead_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.pending != 2'd0) |-> (state_q.lead[7:6] == 2'b11))
		else $error("pending bytes without a lead byte");

	// End and error words carry no code point.
	a_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && (dout.status != utf8d_pkg::ST_CHAR)) |-> (dout.code_point == '0))
		else $error("nonzero code point on end or error word");

endmodule

// File: bench/tb_utf8_validating_decoder_core.sv
// Self-checking testbench for the streaming UTF-8 validating decoder core.
`timescale 1ns / 1ps

module tb_utf8_validating_decoder_core;

	localparam int unsigned CP_W = utf8d_pkg::CP_W;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_WORDS   = 1800;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AFTER     = 150;
	localparam int DRAIN_CYCLES   = 10;
	localparam int PRINT_CAP      = 30;

	// Running decode of the accepted byte stream and the queue of results it predicts.
	class utf8_decode_scoreboard;
		logic [1:0]         pending;
		logic [CP_W-1:0]    partial;
		logic [7:0]         lead;
		logic [7:0]         second;
		bit                 discarding;
		utf8d_pkg::result_t due_results[$];
		int                 mismatches;

		function new();
			clear_state();
			mismatches = 0;
		endfunction

		function void clear_state();
			pending    = '0;
			partial    = '0;
			lead       = '0;
			second     = '0;
			discarding = 1'b0;
		endfunction

		// Decode one accepted word and queue the result it gives, if any.
		function void note_byte(logic [7:0] b);
			utf8d_pkg::result_t r;
			bit                 got;
			bit                 bad;
			logic [1:0]         extra;
			got = 1'b0;
			bad = 1'b0;
			r.code_point = '0;
			r.status = utf8d_pkg::ST_CHAR;
			if (discarding) begin
				if (b == 8'h00)
					clear_state();
			end else if (pending == 2'd0) begin
				if (b == 8'h00) begin
					got = 1'b1;
					r.status = utf8d_pkg::ST_END;
				end else if (b[7] == 1'b0) begin
					got = 1'b1;
					r.code_point = CP_W'(b);
				end else if (b[7:5] == 3'b110) begin
					// C0 and C1 can only start overlong two-byte forms.
					bad = (b[7:1] == 7'h60);
					pending = 2'd1;
					partial = CP_W'(b[4:0]);
				end else if (b[7:4] == 4'hE) begin
					pending = 2'd2;
					partial = CP_W'(b[3:0]);
				end else if (b[7:3] == 5'b11110 && b <= utf8d_pkg::LEAD_F4) begin
					pending = 2'd3;
					partial = CP_W'(b[2:0]);
				end else begin
					// Stray continuation byte or a lead byte beyond F4.
					bad = 1'b1;
				end
				lead   = b;
				second = '0;
			end else if (b[7:6] != 2'b10) begin
				bad = 1'b1;
			end else begin
				if (lead[7:5] == 3'b110)
					extra = 2'd1;
				else if (lead[7:4] == 4'hE)
					extra = 2'd2;
				else
					extra = 2'd3;
				if (pending == extra) begin
					// Second byte: overlong, surrogate and above-range checks.
					bad = (lead == utf8d_pkg::LEAD_E0 && b[7:5] == 3'b100) ||
						(lead == utf8d_pkg::LEAD_ED && b[7:5] == 3'b101) ||
						(lead == utf8d_pkg::LEAD_F0 && b[7:4] == 4'h8) ||
						(lead == utf8d_pkg::LEAD_F4 && b > utf8d_pkg::MAX_F4_SECOND);
					second = b;
				end else if (extra == 2'd2 && pending == 2'd1) begin
					// Last byte of U+FFFE or U+FFFF.
					bad = (lead == utf8d_pkg::LEAD_EF && second == utf8d_pkg::BYTE_BF
						&& b[7:1] == 7'h5F);
				end
				if (!bad) begin
					partial = {partial[CP_W-7:0], b[5:0]};
					pending = pending - 2'd1;
					if (pending == 2'd0) begin
						got = 1'b1;
						r.code_point = partial;
						partial = '0;
						lead    = '0;
						second  = '0;
					end
				end
			end
			// An error on a zero byte ends the string; any other starts discarding.
			if (bad) begin
				clear_state();
				discarding = (b != 8'h00);
				got = 1'b1;
				r.code_point = '0;
				r.status = utf8d_pkg::ST_ERR;
			end
			if (got)
				due_results.push_back(r);
		endfunction

		task report_mismatch(string what);
			if (mismatches < PRINT_CAP)
				$display("MISMATCH at %0t ns: %s", $time, what);
			mismatches++;
		endtask

		// Compare one accepted result word with the oldest prediction.
		task check_result(logic [CP_W-1:0] cp, logic [1:0] st);
			utf8d_pkg::result_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result cp=%h status=%0d", cp, st));
				return;
			end
			want = due_results.pop_front();
			if (cp !== want.code_point)
				report_mismatch($sformatf("code_point %h, expected %h", cp, want.code_point));
			if (st !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
		endtask
	endclass

	logic clk;
	logic arst_n;

	utf8d_byte_if din_if();
	utf8d_res_if  dout_if();

	utf8_validating_decoder_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	utf8_decode_scoreboard sb = new();

	int  sent_words;
	int  results_seen;
	bit  send_calm;
	bit  recv_calm;

	// Clock, and known levels on every input from time zero.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.in_byte = '0;
		dout_if.ready = 1'b0;
	end

	always #5 clk = ~clk;

	// Mostly short gaps, a few long ones, and calm stretches with none.
	function automatic int draw_gap(inout bit calm);
		int r;
		if ($urandom_range(0, 199) == 0)
			calm = ~calm;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// UTF-8 encoding of a scalar value; seq[0] is the lead byte.
	function automatic void utf8_encode(input logic [CP_W-1:0] cp,
		output logic [3:0][7:0] seq, output int n);
		seq = '0;
		if (cp < 'h80) begin
			n = 1;
			seq[0] = cp[7:0];
		end else if (cp < 'h800) begin
			n = 2;
			seq[0] = {3'b110, cp[10:6]};
			seq[1] = {2'b10, cp[5:0]};
		end else if (cp < 'h10000) begin
			n = 3;
			seq[0] = {4'b1110, cp[15:12]};
			seq[1] = {2'b10, cp[11:6]};
			seq[2] = {2'b10, cp[5:0]};
		end else begin
			n = 4;
			seq[0] = {5'b11110, cp[20:18]};
			seq[1] = {2'b10, cp[17:12]};
			seq[2] = {2'b10, cp[11:6]};
			seq[3] = {2'b10, cp[5:0]};
		end
	endfunction

	// Random scalar value whose encoding takes len bytes.
	function automatic logic [CP_W-1:0] draw_scalar(int len);
		logic [CP_W-1:0] cp;
		case (len)
			1: cp = CP_W'($urandom_range(1, 'h7F));
			2: cp = CP_W'($urandom_range('h80, 'h7FF));
			3: begin
				do
					cp = CP_W'($urandom_range('h800, 'hFFFD));
				while (cp >= 'hD800 && cp <= 'hDFFF);
			end
			default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
		endcase
		return cp;
	endfunction

	// Offer one word after a random gap and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		int  gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.in_byte <= b;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		sb.note_byte(b);
		sent_words++;
	endtask

	// Result side: check every accepted word, stall at random, and hold off
	// once for a long stretch so the core fills up and stalls its input.
	initial begin : result_side
		int  stall_left;
		int  hold_left;
		bit  held;
		stall_left = 0;
		hold_left = 0;
		held = 1'b0;
		results_seen = 0;
		recv_calm = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dout_if.valid && dout_if.ready) begin
				sb.check_result(dout_if.code_point, dout_if.status);
				results_seen++;
			end
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= 1'b1;
				stall_left = draw_gap(recv_calm);
			end
		end
	end

	// Watchdog: too many cycles in a row with no word taken on either side.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("TIMEOUT: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Stimulus: directed strings, then random well-formed and broken sequences.
	initial begin : byte_side
		logic [7:0]      directed[$];
		logic [3:0][7:0] seq;
		logic [CP_W-1:0] cp;
		logic [7:0]      lead_pick;
		int              n;
		int              cut;
		int              k;
		int              kind;

		send_calm = 1'b0;
		sent_words = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes and special cases: end, ASCII, smallest and largest
		// scalars, U+FFFF, surrogate, a zero cutting a sequence, leads beyond
		// F4 with discarding, and the overlong three- and four-byte forms.
		directed = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
			8'hEF, 8'hBF, 8'hBF, 8'h00, 8'hED, 8'hA0, 8'h00, 8'hC2, 8'h00,
			8'hF5, 8'h80, 8'h00, 8'hE0, 8'h80, 8'h00, 8'hF0, 8'h8F, 8'h00};
		foreach (directed[i])
			send_byte(directed[i]);

		sent_words = 0;
		while (sent_words < RANDOM_WORDS) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				// Well-formed character of random length.
				utf8_encode(draw_scalar($urandom_range(1, 4)), seq, n);
				for (k = 0; k < n; k++)
					send_byte(seq[k]);
			end else if (kind < 55) begin
				send_byte(8'h00);
			end else if (kind < 70) begin
				// Lead bytes, chiefly those with range checks, followed by random continuation bytes,
				// so the limits of each check get hit.
				case ($urandom_range(0, 12))
					0: lead_pick = 8'hC0;
					1: lead_pick = 8'hC1;
					2: lead_pick = 8'hC2;
					3: lead_pick = 8'hDF;
					4: lead_pick = utf8d_pkg::LEAD_E0;
					5: lead_pick = utf8d_pkg::LEAD_ED;
					6: lead_pick = utf8d_pkg::LEAD_EF;
					7: lead_pick = utf8d_pkg::LEAD_F0;
					8: lead_pick = utf8d_pkg::LEAD_F4;
					9: lead_pick = 8'($urandom_range('hF5, 'hFF));
					10: lead_pick = 8'($urandom_range('h80, 'hBF));
					11: lead_pick = 8'($urandom_range('hE1, 'hEC));
					default: lead_pick = 8'($urandom_range('hF1, 'hF3));
				endcase
				send_byte(lead_pick);
				if (lead_pick == utf8d_pkg::LEAD_EF && $urandom_range(0, 1) == 1) begin
					send_byte(utf8d_pkg::BYTE_BF);
					send_byte(8'($urandom_range('hBC, 'hBF)));
				end else begin
					n = $urandom_range(1, 3);
					for (k = 0; k < n; k++)
						send_byte(8'($urandom_range('h80, 'hBF)));
				end
			end else if (kind < 85) begin
				// Sequence cut short by a byte that is not a continuation.
				cp = draw_scalar($urandom_range(2, 4));
				utf8_encode(cp, seq, n);
				cut = $urandom_range(1, n - 1);
				if ($urandom_range(0, 3) == 0)
					seq[cut] = 8'h00;
				else if ($urandom_range(0, 1) == 1)
					seq[cut] = 8'($urandom_range(1, 'h7F));
				else
					seq[cut] = 8'($urandom_range('hC0, 'hFF));
				for (k = 0; k <= cut; k++)
					send_byte(seq[k]);
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
			// Recover from discarding fairly often so most words are decoded.
			if (sb.discarding && $urandom_range(0, 2) == 0)
				send_byte(8'h00);
		end
		din_if.valid <= 1'b0;

		// Drain: wait until all predictions are met, then keep watching for stray results.
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
sv/utf8d_pkg.sv
sv/utf8d_if.sv
sv/utf8d_step.sv
sv/utf8d_obuf.sv
sv/utf8_validating_decoder_core.sv
bench/tb_utf8_validating_decoder_core.sv
